FILE: design/bbcd_pkg.sv
// ----------------------------------------------------------------------------
// Block buffer cache directory package
// Shared types, constants and command/status structures.
// ----------------------------------------------------------------------------
package bbcd_pkg;

    localparam int NUM_SLOTS_DEF  = 64;
    localparam int COUNT_BITS_DEF = 8;
    localparam int DEV_W          = 8;
    localparam int BLK_W          = 32;
    localparam int SPB_W          = 4;
    localparam int SECT_W         = 35;
    localparam int SLOT_OUT_W     = 6;
    localparam logic [SPB_W-1:0] SPB_RESET = 4'd2;

    localparam logic [1:0] OP_READ      = 2'd0;
    localparam logic [1:0] OP_DIRTY     = 2'd1;
    localparam logic [1:0] OP_WRITEBACK = 2'd2;
    localparam logic [1:0] OP_RELEASE   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RETRY = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the input item
        logic scan_start; // clear scan index
        logic scan_step;  // read next tag entry
        logic rd_slot;    // read entry of the selected slot
        logic execute;    // apply the update and form the result
        logic mul_step;   // one partial product step
        logic out_load;   // present the result
    } t_cmd;

    typedef struct packed {
        logic scan_hit;   // registered compare of last entry matched
        logic scan_done;  // last entry has been compared
        logic mul_done;
    } t_stat;

endpackage

FILE: design/bbcd_ctrl.sv
// ----------------------------------------------------------------------------
// Block buffer cache directory controller
// Sequences capture, tag scan, slot read, update, sector multiply and output.
// ----------------------------------------------------------------------------
module bbcd_ctrl
    import bbcd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_op_is_read,
    output t_cmd  o_cmd,
    input  t_stat i_stat,
    input  logic  i_out_free
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_RSLOT = 7'b0000100,
        S_WAIT  = 7'b0001000,
        S_EXEC  = 7'b0010000,
        S_MUL   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // Non-read commands skip the search.
                if (!i_op_is_read || i_stat.scan_hit || i_stat.scan_done) begin
                    n_state = S_RSLOT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_RSLOT: begin
                o_cmd.rd_slot = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                if (i_stat.mul_done) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: design/bbcd_dp.sv
// ----------------------------------------------------------------------------
// Block buffer cache directory datapath
// Tag memories, per-slot flags and counts, LRU free list, sector multiplier.
// ----------------------------------------------------------------------------
module bbcd_dp
    import bbcd_pkg::*;
#(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    output logic              o_op_is_read,
    input  logic [1:0]        i_opcode,
    input  logic [DEV_W-1:0]  i_device,
    input  logic [BLK_W-1:0]  i_block_number,
    input  logic [5:0]        i_slot_index,
    input  logic [SPB_W-1:0]  i_spb,
    output logic [1:0]        o_status,
    output logic [SLOT_OUT_W-1:0] o_buffer_slot,
    output logic              o_found_valid,
    output logic              o_fetch_request,
    output logic              o_writeback_request,
    output logic [DEV_W-1:0]  o_request_device,
    output logic [SECT_W-1:0] o_request_sector,
    output logic              o_slot_freed
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int UW = $clog2(NUM_SLOTS + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    // Tag and link memories: one write port, read data registered.
    logic [DEV_W-1:0] m_dev [NUM_SLOTS];
    logic [BLK_W-1:0] m_blk [NUM_SLOTS];
    logic [SW-1:0]    m_newer [NUM_SLOTS];
    logic [SW-1:0]    m_older [NUM_SLOTS];
    logic [COUNT_BITS-1:0] m_cnt [NUM_SLOTS];

    logic [NUM_SLOTS-1:0] r_dirty, r_onfree;
    logic [SW-1:0] r_newest, r_oldest;
    logic          r_fempty;
    logic [UW-1:0] r_inuse;

    logic [1:0]        r_op;
    logic [DEV_W-1:0]  r_dev;
    logic [BLK_W-1:0]  r_blk;
    logic [5:0]        r_idx;

    logic [UW-1:0] r_scan;
    logic [SW-1:0] r_cmp_slot;
    logic          r_cmp_vld, r_hit;
    logic [DEV_W-1:0] r_rd_dev;
    logic [BLK_W-1:0] r_rd_blk;

    logic [SW-1:0] r_slot;
    logic          r_miss;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [DEV_W-1:0] r_sl_dev;
    logic [BLK_W-1:0] r_sl_blk;
    logic [SW-1:0] r_lnewer, r_lolder;

    // Result registers.
    logic [1:0]  r_status;
    logic [5:0]  r_rslot;
    logic        r_found, r_fetch, r_wb, r_freed;
    logic [DEV_W-1:0] r_rdev;
    logic [BLK_W-1:0] r_mcand;
    logic [SECT_W-1:0] r_acc;
    logic [SPB_W-1:0]  r_mplier;
    logic [2:0]  r_mcnt;

    assign o_op_is_read = (r_op == OP_READ);

    // Scan: read entry r_scan, compare registered data next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
            r_hit <= 1'b0;
            r_scan <= '0;
        end else if (i_cmd.scan_start) begin
            r_cmp_vld <= 1'b0;
            r_hit <= 1'b0;
            r_scan <= '0;
        end else if (i_cmd.scan_step) begin
            if (r_scan < r_inuse) begin
                r_rd_dev <= m_dev[r_scan[SW-1:0]];
                r_rd_blk <= m_blk[r_scan[SW-1:0]];
                r_cmp_slot <= r_scan[SW-1:0];
                r_cmp_vld <= 1'b1;
                r_scan <= r_scan + 1'b1;
            end else begin
                r_cmp_vld <= 1'b0;
            end
            if (r_cmp_vld && r_rd_dev == r_dev && r_rd_blk == r_blk) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_comb begin
        o_stat.scan_hit  = r_hit;
        o_stat.scan_done = !r_cmp_vld && (r_scan >= r_inuse) && !r_hit
                           && (r_scan != '0 || r_inuse == '0);
        o_stat.mul_done  = (r_mcnt == 3'd0);
    end

    // Hit slot is the one compared just before r_hit rose; keep a copy.
    logic [SW-1:0] r_hit_slot;
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && r_cmp_vld && r_rd_dev == r_dev && r_rd_blk == r_blk) begin
            r_hit_slot <= r_cmp_slot;
        end
    end

    // Slot selection and registered read of its entry.
    logic [SW-1:0] sel_slot;
    logic          sel_miss;
    always_comb begin
        sel_miss = 1'b0;
        if (r_op != OP_READ) begin
            sel_slot = r_idx[SW-1:0];
        end else if (r_hit) begin
            sel_slot = r_hit_slot;
        end else begin
            sel_miss = 1'b1;
            sel_slot = (r_inuse < UW'(NUM_SLOTS)) ? r_inuse[SW-1:0] : r_oldest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_opcode;
            r_dev <= i_device;
            r_blk <= i_block_number;
            r_idx <= i_slot_index;
        end
        if (i_cmd.rd_slot) begin
            r_slot <= sel_slot;
            r_miss <= sel_miss;
            r_cnt <= m_cnt[sel_slot];
            r_sl_dev <= m_dev[sel_slot];
            r_sl_blk <= m_blk[sel_slot];
            r_lnewer <= m_newer[sel_slot];
            r_lolder <= m_older[sel_slot];
        end
    end

    // Update step.
    logic idx_ok;
    assign idx_ok = ({{(16-6){1'b0}}, r_idx} < 16'(r_inuse))
                    && (int'(r_idx) < NUM_SLOTS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty <= '0;
            r_onfree <= '0;
            r_newest <= '0;
            r_oldest <= '0;
            r_fempty <= 1'b1;
            r_inuse <= '0;
            r_mcnt <= '0;
        end else if (i_cmd.execute) begin
            r_status <= ST_OK;
            r_rslot <= 6'(r_slot);
            r_found <= 1'b0;
            r_fetch <= 1'b0;
            r_wb <= 1'b0;
            r_freed <= 1'b0;
            r_rdev <= '0;
            r_mcand <= '0;
            r_mcnt <= '0;
            if (r_op == OP_READ) begin
                if (!r_miss) begin
                    if (r_cnt == CMAX) begin
                        r_status <= ST_SAT;
                    end else begin
                        if (r_onfree[r_slot]) begin
                            r_onfree[r_slot] <= 1'b0;
                            if (r_slot == r_newest && r_slot == r_oldest) begin
                                r_fempty <= 1'b1;
                            end else if (r_slot == r_newest) begin
                                r_newest <= r_lolder;
                            end else if (r_slot == r_oldest) begin
                                r_oldest <= r_lnewer;
                            end else begin
                                m_older[r_lnewer] <= r_lolder;
                                m_newer[r_lolder] <= r_lnewer;
                            end
                        end
                        m_cnt[r_slot] <= r_cnt + 1'b1;
                        r_found <= 1'b1;
                    end
                end else if (r_inuse < UW'(NUM_SLOTS) || !r_fempty) begin
                    if (r_inuse < UW'(NUM_SLOTS)) begin
                        r_inuse <= r_inuse + 1'b1;
                    end else begin
                        r_onfree[r_slot] <= 1'b0;
                        if (r_slot == r_newest) begin
                            r_fempty <= 1'b1;
                        end else begin
                            r_oldest <= r_lnewer;
                        end
                    end
                    m_dev[r_slot] <= r_dev;
                    m_blk[r_slot] <= r_blk;
                    m_cnt[r_slot] <= COUNT_BITS'(1);
                    r_dirty[r_slot] <= 1'b0;
                    r_fetch <= 1'b1;
                    r_rdev <= r_dev;
                    r_mcand <= r_blk;
                    r_mcnt <= 3'(SPB_W);
                end else begin
                    r_status <= ST_RETRY;
                    r_rslot <= '0;
                end
            end else if (!idx_ok) begin
                r_status <= ST_BAD;
                r_rslot <= r_idx;
            end else begin
                r_rslot <= r_idx;
                case (r_op)
                    OP_DIRTY: begin
                        if (r_cnt == '0) r_status <= ST_BAD;
                        else r_dirty[r_slot] <= 1'b1;
                    end
                    OP_WRITEBACK: begin
                        if (r_dirty[r_slot]) begin
                            r_dirty[r_slot] <= 1'b0;
                            r_wb <= 1'b1;
                            r_rdev <= r_sl_dev;
                            r_mcand <= r_sl_blk;
                            r_mcnt <= 3'(SPB_W);
                        end
                    end
                    default: begin
                        if (r_cnt == '0) begin
                            r_status <= ST_BAD;
                        end else begin
                            if (r_dirty[r_slot]) begin
                                r_dirty[r_slot] <= 1'b0;
                                r_wb <= 1'b1;
                                r_rdev <= r_sl_dev;
                                r_mcand <= r_sl_blk;
                                r_mcnt <= 3'(SPB_W);
                            end
                            m_cnt[r_slot] <= r_cnt - 1'b1;
                            if (r_cnt == COUNT_BITS'(1)) begin
                                // Push as most recently released.
                                m_older[r_slot] <= r_newest;
                                if (r_fempty) r_oldest <= r_slot;
                                else m_newer[r_newest] <= r_slot;
                                r_newest <= r_slot;
                                r_fempty <= 1'b0;
                                r_onfree[r_slot] <= 1'b1;
                                r_freed <= 1'b1;
                            end
                        end
                    end
                endcase
            end
        end else if (i_cmd.mul_step) begin
            r_mcnt <= r_mcnt - 1'b1;
        end
    end

    // Shift-add multiply, one multiplier bit per cycle, MSB first.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_acc <= '0;
            r_mplier <= i_spb;
        end else if (i_cmd.mul_step) begin
            r_acc <= (r_acc << 1) + (r_mplier[SPB_W-1] ? SECT_W'(r_mcand) : '0);
            r_mplier <= r_mplier << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status <= r_status;
            o_buffer_slot <= r_rslot;
            o_found_valid <= r_found;
            o_fetch_request <= r_fetch;
            o_writeback_request <= r_wb;
            o_request_device <= r_rdev;
            o_request_sector <= (r_fetch || r_wb) ? r_acc : '0;
            o_slot_freed <= r_freed;
        end
    end

endmodule

FILE: design/block_buffer_cache_directory_core.sv
// Time from input transfer to result grows with the slot of a read hit, and on a read
// miss with the number of slots in use.
// The tag scan reads one entry per cycle; fetch and write back add a shift-add multiply.
// One command at a time; the next is taken once the result is in the output register.
// The result sits in an output register, and the next command may enter while it waits.
// Reset (synchronous, active low) empties the directory and sets two sectors per block.
// ----------------------------------------------------------------------------
// Block buffer cache directory core
// LRU buffer cache directory with tag scan, free list, fetch and write-back requests.
// ----------------------------------------------------------------------------
module block_buffer_cache_directory_core
    import bbcd_pkg::*;
#(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SPB_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_opcode,
    input  logic [DEV_W-1:0]  i_device,
    input  logic [BLK_W-1:0]  i_block_number,
    input  logic [5:0]        i_slot_index,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_status,
    output logic [5:0]        o_buffer_slot,
    output logic              o_found_valid,
    output logic              o_fetch_request,
    output logic              o_writeback_request,
    output logic [DEV_W-1:0]  o_request_device,
    output logic [SECT_W-1:0] o_request_sector,
    output logic              o_slot_freed
);

    t_cmd  cmd;
    t_stat stat;
    logic  op_is_read;
    logic  r_out_valid;
    logic [SPB_W-1:0] r_spb;
    logic  out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spb <= SPB_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_spb <= i_cfg_wdata;
            if (cmd.out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    bbcd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_op_is_read(op_is_read), .o_cmd(cmd), .i_stat(stat),
        .i_out_free(out_free)
    );

    bbcd_dp #(.NUM_SLOTS(NUM_SLOTS), .COUNT_BITS(COUNT_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_stat(stat), .o_op_is_read(op_is_read),
        .i_opcode(i_opcode), .i_device(i_device),
        .i_block_number(i_block_number), .i_slot_index(i_slot_index),
        .i_spb(r_spb),
        .o_status(o_status), .o_buffer_slot(o_buffer_slot),
        .o_found_valid(o_found_valid), .o_fetch_request(o_fetch_request),
        .o_writeback_request(o_writeback_request),
        .o_request_device(o_request_device),
        .o_request_sector(o_request_sector), .o_slot_freed(o_slot_freed)
    );

    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_fetch_request && o_writeback_request))
        else $error("fetch and write back in one result");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found_valid) |-> (o_status == ST_OK))
        else $error("hit with nonzero status");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> !o_in_ready)
        else $error("second command accepted while busy");

endmodule

FILE: dv/tb_block_buffer_cache_directory_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block buffer cache directory testbench
// Drives read, mark-dirty, write-back and release commands through the
// handshake ports and checks every result against a behavioral model of the
// directory (tag search, LRU free list, reference counts, fetch and write
// back requests) kept in a scoreboard class.
// ----------------------------------------------------------------------------
module tb_block_buffer_cache_directory_core;
    import bbcd_pkg::*;

    localparam int NSLOT = 64;
    localparam int CMAX  = 255;

    typedef struct packed {
        logic [1:0]        status;
        logic [5:0]        slot;
        logic              found;
        logic              fetch;
        logic              wback;
        logic [DEV_W-1:0]  rdev;
        logic [SECT_W-1:0] sector;
        logic              freed;
    } dir_result_t;

    class directory_scoreboard;
        logic [8:0]       tag_dev [NSLOT];
        logic [BLK_W-1:0] tag_blk [NSLOT];
        int               refs    [NSLOT];
        bit               dirty   [NSLOT];
        bit               on_list [NSLOT];
        int               newer   [NSLOT];
        int               older   [NSLOT];
        int               newest, oldest, in_use;
        bit               list_empty;
        logic [SPB_W-1:0] spb;
        dir_result_t      pending [$];
        int               errors;

        function new();
            for (int i = 0; i < NSLOT; i++) begin
                tag_dev[i] = 9'd256; tag_blk[i] = '0; refs[i] = 0;
                dirty[i] = 0; on_list[i] = 0; newer[i] = 0; older[i] = 0;
            end
            newest = 0; oldest = 0; in_use = 0; list_empty = 1;
            spb = SPB_RESET; errors = 0;
        endfunction

        function void unlink(int s);
            if (s == newest && s == oldest) list_empty = 1;
            else if (s == newest) newest = older[s];
            else if (s == oldest) oldest = newer[s];
            else begin
                older[newer[s]] = older[s];
                newer[older[s]] = newer[s];
            end
            on_list[s] = 0;
        endfunction

        function void request(ref dir_result_t r, input int s);
            r.rdev   = tag_dev[s][7:0];
            r.sector = SECT_W'({3'b0, tag_blk[s]} * spb);
        endfunction

        function void note_command(logic [1:0] op, logic [7:0] dev,
                                   logic [31:0] blk, logic [5:0] idx);
            dir_result_t r;
            int s;
            r = '0;
            if (op == OP_READ) begin
                for (int i = 0; i < in_use; i++)
                    if (tag_dev[i] == {1'b0, dev} && tag_blk[i] == blk) begin
                        r.slot = 6'(i);
                        if (refs[i] >= CMAX) r.status = ST_SAT;
                        else begin
                            if (on_list[i]) unlink(i);
                            refs[i]++;
                            r.found = 1;
                        end
                        pending.push_back(r);
                        return;
                    end
                if (in_use < NSLOT) begin
                    s = in_use; in_use++;
                end else if (!list_empty) begin
                    s = oldest; unlink(s);
                end else begin
                    r.status = ST_RETRY;
                    pending.push_back(r);
                    return;
                end
                tag_dev[s] = {1'b0, dev}; tag_blk[s] = blk;
                refs[s] = 1; dirty[s] = 0;
                r.slot = 6'(s); r.fetch = 1;
                request(r, s);
                pending.push_back(r);
                return;
            end
            r.slot = idx;
            s = int'(idx);
            if (s >= in_use) r.status = ST_BAD;
            else if (op == OP_DIRTY) begin
                if (refs[s] == 0) r.status = ST_BAD; else dirty[s] = 1;
            end else if (op == OP_WRITEBACK) begin
                if (dirty[s]) begin
                    r.wback = 1; request(r, s); dirty[s] = 0;
                end
            end else if (refs[s] == 0) r.status = ST_BAD;
            else begin
                if (dirty[s]) begin
                    r.wback = 1; request(r, s); dirty[s] = 0;
                end
                refs[s]--;
                if (refs[s] == 0) begin
                    older[s] = newest;
                    if (list_empty) oldest = s; else newer[newest] = s;
                    newest = s; list_empty = 0; on_list[s] = 1;
                    r.freed = 1;
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(dir_result_t got);
            dir_result_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                $display("%0t: mismatch expected %h actual %h", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_cfg_we = 0;
    logic [SPB_W-1:0]  i_cfg_wdata = '0;
    logic              i_in_valid = 0;
    logic              o_in_ready;
    logic [1:0]        i_opcode = '0;
    logic [DEV_W-1:0]  i_device = '0;
    logic [BLK_W-1:0]  i_block_number = '0;
    logic [5:0]        i_slot_index = '0;
    logic              o_out_valid;
    logic              i_out_ready = 0;
    logic [1:0]        o_status;
    logic [5:0]        o_buffer_slot;
    logic              o_found_valid, o_fetch_request, o_writeback_request;
    logic [DEV_W-1:0]  o_request_device;
    logic [SECT_W-1:0] o_request_sector;
    logic              o_slot_freed;

    block_buffer_cache_directory_core dut (.*);

    always #5 i_clk = ~i_clk;

    directory_scoreboard sb = new();
    int  send_idle = 0;   // percent of cycles the sender idles
    int  recv_stall = 0;  // percent of cycles the receiver stalls
    bit  hold_off = 0;
    longint cycles = 0;
    // Blocks seen by reads; reuse them so that hits and evictions are common.
    logic [7:0]  seen_dev [$];
    logic [31:0] seen_blk [$];

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("tb_block_buffer_cache_directory_core failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready)
            sb.check_result({o_status, o_buffer_slot, o_found_valid, o_fetch_request,
                             o_writeback_request, o_request_device,
                             o_request_sector, o_slot_freed});
        i_out_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
    end

    // Valid stays high from one transfer to the next unless the sender idles.
    task automatic send(logic [1:0] op, logic [7:0] dev, logic [31:0] blk,
                        logic [5:0] idx);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1; i_opcode <= op; i_device <= dev;
        i_block_number <= blk; i_slot_index <= idx;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_command(op, dev, blk, idx);
        if (op == OP_READ) begin
            seen_dev.push_back(dev); seen_blk.push_back(blk);
        end
    endtask

    task automatic drain_and_write(logic [SPB_W-1:0] v);
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.spb = v;
    endtask

    task automatic random_command();
        int k;
        int pick;
        k = $urandom_range(99);
        if (k < 45) begin
            if (seen_dev.size() > 0 && $urandom_range(1)) begin
                pick = $urandom_range(seen_dev.size() - 1);
                send(OP_READ, seen_dev[pick], seen_blk[pick], '0);
            end else
                send(OP_READ, 8'($urandom), $urandom, 6'($urandom));
        end else begin
            // Mostly slots in use, sometimes any slot.
            if (sb.in_use > 0 && $urandom_range(9) != 0)
                send(2'($urandom_range(3, 1)), 8'($urandom), $urandom,
                     6'($urandom_range(sb.in_use - 1)));
            else
                send(2'($urandom_range(3, 1)), 8'($urandom), $urandom, 6'($urandom));
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes, each command, and the error cases.
        send(OP_DIRTY, 8'h00, '0, 6'd0);          // unassigned slot
        send(OP_READ, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        send(OP_READ, 8'h00, 32'h0, 6'd0);
        send(OP_READ, 8'hFF, 32'hFFFF_FFFF, 6'd0); // hit
        send(OP_DIRTY, 8'h00, '0, 6'd0);
        send(OP_WRITEBACK, 8'h00, '0, 6'd0);
        send(OP_WRITEBACK, 8'h00, '0, 6'd0);       // clean write back
        send(OP_DIRTY, 8'h00, '0, 6'd0);
        send(OP_RELEASE, 8'h00, '0, 6'd0);         // write back on release
        send(OP_RELEASE, 8'h00, '0, 6'd0);         // count to zero
        send(OP_RELEASE, 8'h00, '0, 6'd0);         // underflow
        send(OP_DIRTY, 8'h00, '0, 6'd0);           // dirty on a free slot
        send(OP_RELEASE, 8'h00, '0, 6'd1);
        send(OP_READ, 8'hFF, 32'hFFFF_FFFF, 6'd0); // hit from the free list
        send(OP_RELEASE, 8'h00, '0, 6'h3F);        // unassigned slot
        drain_and_write(4'd8);
        send(OP_READ, 8'hA5, 32'hFFFF_FFFF, 6'd0);
        send(OP_DIRTY, 8'h00, '0, 6'd2);
        send(OP_WRITEBACK, 8'h00, '0, 6'd2);
        drain_and_write(4'd0);
        send(OP_READ, 8'h5A, 32'h1234_5678, 6'd0);
        // Saturate one count.
        for (int i = 0; i < CMAX; i++) send(OP_READ, 8'h5A, 32'h1234_5678, 6'd0);
        drain_and_write(4'd15);

        // Random phases: no idling, sender idle, receiver stalls, both.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = (ph == 1) ? 85 : (ph == 3) ? 24 : 0;
            recv_stall = (ph == 2) ? 85 : (ph == 3) ? 24 : 0;
            if (ph == 2) begin
                // Long hold-off while commands keep coming.
                fork
                    begin hold_off = 1; repeat (400) @(posedge i_clk); hold_off = 0; end
                    for (int i = 0; i < 20; i++) random_command();
                join
            end
            for (int i = 0; i < 130; i++) random_command();
            // Fill the pool and pin it to reach the empty-pool case.
            if (ph == 1) begin
                for (int i = 0; i < 70; i++) send(OP_READ, 8'($urandom), $urandom, '0);
                send(OP_READ, 8'h77, 32'h7777_7777, '0);
                for (int i = 0; i < 64; i++) send(OP_RELEASE, '0, '0, 6'(i));
            end
            drain_and_write(ph == 0 ? 4'd1 : ph == 1 ? 4'd3 : ph == 2 ? 4'd7 : 4'd2);
        end

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_block_buffer_cache_directory_core passed");
        else
            $display("tb_block_buffer_cache_directory_core failed");
        $finish;
    end
endmodule

FILE: block_buffer_cache_directory_core.f
design/bbcd_pkg.sv
design/bbcd_ctrl.sv
design/bbcd_dp.sv
design/block_buffer_cache_directory_core.sv
dv/tb_block_buffer_cache_directory_core.sv
